/* rtl/samt_pkg.sv */
// ----------------------------------------------------------------------------
// samt_pkg
// Shared types and constants for the secure address mapping table: request
// and response beats, the stored slot word, operation codes and scan states.
// ----------------------------------------------------------------------------
package samt_pkg;

    // width of the reported slot index
    localparam int IDX_OUT_W = 6;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD         = 2'd0,
        OP_LOOKUP_ADDR = 2'd1,
        OP_LOOKUP_SEC  = 2'd2,
        OP_REMOVE      = 2'd3
    } t_op;

    // request beat
    typedef struct packed {
        t_op         operation;
        logic [47:0] address_key;
        logic [63:0] secure_high;
        logic [63:0] secure_low;
        logic [63:0] ident_high;
        logic [63:0] ident_low;
    } t_in;

    // response beat
    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] slot_index;
        logic [47:0]          address_out;
        logic [63:0]          secure_high_out;
        logic [63:0]          secure_low_out;
        logic [63:0]          ident_high_out;
        logic [63:0]          ident_low_out;
    } t_out;

    // one stored slot, valid mark included
    typedef struct packed {
        logic        valid;
        logic [47:0] address;
        logic [63:0] secure_high;
        logic [63:0] secure_low;
        logic [63:0] ident_high;
        logic [63:0] ident_low;
    } t_slot;

    // compare unit result for one slot
    typedef struct packed {
        logic match;
        logic free;
    } t_cmp;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE,
        ST_RESP
    } t_state;

endpackage

/* rtl/samt_ram.sv */
// ----------------------------------------------------------------------------
// samt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module samt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/samt_cmp.sv */
// ----------------------------------------------------------------------------
// samt_cmp
// Shared key compare unit: checks one slot word against the request keys
// under the rules of the current operation.
// ----------------------------------------------------------------------------
module samt_cmp (
    input  samt_pkg::t_in   i_req,
    input  samt_pkg::t_slot i_slot,
    output samt_pkg::t_cmp  o_res
);

    logic addr_eq;
    logic sec_eq;

    // key equality
    assign addr_eq = (i_slot.address == i_req.address_key);
    assign sec_eq  = (i_slot.secure_high == i_req.secure_high) &&
                     (i_slot.secure_low == i_req.secure_low);

    // add sees stale slots too, the others valid slots only
    always_comb begin
        o_res = '0;
        case (i_req.operation)
            samt_pkg::OP_ADD: begin
                o_res.match = addr_eq || sec_eq;
                o_res.free  = !i_slot.valid;
            end
            samt_pkg::OP_LOOKUP_ADDR, samt_pkg::OP_REMOVE: begin
                o_res.match = i_slot.valid && addr_eq;
            end
            samt_pkg::OP_LOOKUP_SEC: begin
                o_res.match = i_slot.valid && sec_eq;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

/* rtl/secure_address_mapping_table.sv */
// Timing: an accepted item starts a scan that reads the slot RAM one slot per cycle
// and compares each returned slot; the scan ends at the last slot or early on a match.
// Flow: one item at a time; no new item is accepted until the response is taken.
// Reset: a clearing pass zeroes every slot in turn; no item is
// accepted until it ends.
// ----------------------------------------------------------------------------
// secure_address_mapping_table
// Associative table mapping a network address key to a secure address and
// identifier. A sequencer scans the slot RAM through one shared compare unit.
// ----------------------------------------------------------------------------
module secure_address_mapping_table #(
    parameter int SLOT_COUNT = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  samt_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output samt_pkg::t_out o_out
);

    localparam int              IW       = $clog2(SLOT_COUNT);
    localparam int              SW       = $bits(samt_pkg::t_slot);
    localparam logic [IW:0]     LP_SLOTS = (IW + 1)'(SLOT_COUNT);
    localparam logic [IW-1:0]   LP_LAST  = IW'(SLOT_COUNT - 1);

    samt_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_clr_idx, n_clr_idx;
    logic [IW:0]      r_issue, n_issue;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]    r_cmp_idx, n_cmp_idx;
    logic             r_hit, n_hit;
    logic [IW-1:0]    r_hit_idx, n_hit_idx;
    logic             r_free_vld, n_free_vld;
    logic [IW-1:0]    r_free_idx, n_free_idx;
    samt_pkg::t_in    r_req, n_req;
    samt_pkg::t_slot  r_hit_slot, n_hit_slot;
    samt_pkg::t_out   r_out, n_out;

    logic             ram_wr_en;
    logic [IW-1:0]    ram_wr_addr;
    samt_pkg::t_slot  ram_wr_data;
    logic             ram_rd_en;
    logic [IW-1:0]    ram_rd_addr;
    logic [SW-1:0]    ram_rd_bits;
    samt_pkg::t_slot  rd_slot;
    samt_pkg::t_cmp   cmp_res;

    logic             sel_found;
    logic [IW-1:0]    sel_idx;
    logic [IW+5:0]    sel_idx_ext;

    // slot storage
    samt_ram #(
        .WIDTH (SW),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (SW'(ram_wr_data)),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_bits)
    );

    assign rd_slot = samt_pkg::t_slot'(ram_rd_bits);

    // shared compare unit
    samt_cmp u_cmp (
        .i_req  (r_req),
        .i_slot (rd_slot),
        .o_res  (cmp_res)
    );

    // chosen slot at the end of the scan
    always_comb begin
        sel_found = 1'b0;
        sel_idx   = '0;
        if (r_hit) begin
            sel_found = 1'b1;
            sel_idx   = r_hit_idx;
        end else if (r_free_vld) begin
            sel_found = 1'b1;
            sel_idx   = r_free_idx;
        end
    end

    assign sel_idx_ext = {6'd0, sel_idx};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= samt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_issue    <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
        end else begin
            r_clr_idx  <= n_clr_idx;
            r_issue    <= n_issue;
            r_cmp_vld  <= n_cmp_vld;
            r_hit      <= n_hit;
            r_free_vld <= n_free_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_req      <= n_req;
        r_hit_slot <= n_hit_slot;
        r_out      <= n_out;
    end

    // sequencer: next state, ram control and response build
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_issue     = r_issue;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free_vld  = r_free_vld;
        n_free_idx  = r_free_idx;
        n_req       = r_req;
        n_hit_slot  = r_hit_slot;
        n_out       = r_out;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_clr_idx;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_issue[IW-1:0];
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        case (r_state)
            // zero every slot after reset
            samt_pkg::ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_idx;
                ram_wr_data = '0;
                n_clr_idx   = r_clr_idx + 1'b1;
                if (r_clr_idx == LP_LAST) begin
                    n_state = samt_pkg::ST_IDLE;
                end
            end

            // take a request beat
            samt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req      = i_in;
                    n_issue    = '0;
                    n_cmp_vld  = 1'b0;
                    n_hit      = 1'b0;
                    n_free_vld = 1'b0;
                    n_state    = samt_pkg::ST_SCAN;
                end
            end

            // read one slot per cycle, compare the one returned
            samt_pkg::ST_SCAN: begin
                if (r_issue < LP_SLOTS) begin
                    ram_rd_en = 1'b1;
                    n_issue   = r_issue + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_issue[IW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld) begin
                    if (cmp_res.match) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_cmp_idx;
                        n_hit_slot = rd_slot;
                        n_state    = samt_pkg::ST_DONE;
                    end else begin
                        if (cmp_res.free && !r_free_vld) begin
                            n_free_vld = 1'b1;
                            n_free_idx = r_cmp_idx;
                        end
                        if (r_cmp_idx == LP_LAST) begin
                            n_state = samt_pkg::ST_DONE;
                        end
                    end
                end
            end

            // update the chosen slot for add or remove and build the response
            samt_pkg::ST_DONE: begin
                ram_wr_addr      = sel_idx;
                n_out            = '0;
                n_out.found      = sel_found;
                n_out.slot_index = sel_idx_ext[5:0];
                case (r_req.operation)
                    samt_pkg::OP_ADD: begin
                        ram_wr_en               = sel_found;
                        ram_wr_data.valid       = 1'b1;
                        ram_wr_data.address     = r_req.address_key;
                        ram_wr_data.secure_high = r_req.secure_high;
                        ram_wr_data.secure_low  = r_req.secure_low;
                        ram_wr_data.ident_high  = r_req.ident_high;
                        ram_wr_data.ident_low   = r_req.ident_low;
                    end
                    samt_pkg::OP_LOOKUP_ADDR: begin
                        if (r_hit) begin
                            n_out.secure_high_out = r_hit_slot.secure_high;
                            n_out.secure_low_out  = r_hit_slot.secure_low;
                            n_out.ident_high_out  = r_hit_slot.ident_high;
                            n_out.ident_low_out   = r_hit_slot.ident_low;
                        end
                    end
                    samt_pkg::OP_LOOKUP_SEC: begin
                        if (r_hit) begin
                            n_out.address_out = r_hit_slot.address;
                        end
                    end
                    samt_pkg::OP_REMOVE: begin
                        // clear the valid mark, keep the stored keys
                        ram_wr_en         = r_hit;
                        ram_wr_data       = r_hit_slot;
                        ram_wr_data.valid = 1'b0;
                    end
                    default: begin
                        ram_wr_en = 1'b0;
                    end
                endcase
                n_state = samt_pkg::ST_RESP;
            end

            // hold the response beat until taken
            samt_pkg::ST_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = samt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = samt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out = r_out;

    // no slot is written while the scan is reading
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == samt_pkg::ST_SCAN) |-> !ram_wr_en)
        else $error("slot write during scan");

    // request and response sides never open together
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready while a response is pending");

    // a free slot is only tracked for add
    a_free_add_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == samt_pkg::ST_DONE && r_free_vld) |->
        (r_req.operation == samt_pkg::OP_ADD))
        else $error("free slot tracked outside add");

    // an accepted beat starts a scan with a clean result
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == samt_pkg::ST_SCAN && !r_hit && !r_cmp_vld))
        else $error("scan did not start cleanly");

    // a miss reports slot zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.found) |-> (o_out.slot_index == '0))
        else $error("miss with nonzero slot index");

endmodule
